@@ rtl/wsd_pkg.sv @@
// Shared types and constants of the moving-window standard deviation filter.
package wsd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 28;
    localparam int SQ_W       = 50;
    localparam int ROWS_W     = 5;
    localparam int HALF_W     = 3;
    localparam int WIDTH_W    = HALF_W + 1;
    localparam int ROW_CNT_W  = 4;
    localparam int MAX_ROWS   = 16;
    localparam int RING_DEPTH = 15;
    localparam int RING_AW    = 4;
    localparam int ENTRY_W    = SUM_W + SQ_W + 2;
    localparam int SEEN_W     = 13;
    localparam int SEEN_LIMIT = 8191;
    localparam int COL_W      = 12;
    localparam int S1_W       = 32;
    localparam int S2_W       = 54;
    localparam int N_W        = 8;
    localparam int DEN_W      = 16;
    localparam int NUM_W      = 62;
    localparam int FRAC_SHIFT = 16;
    localparam int QUO_W      = NUM_W + FRAC_SHIFT;
    localparam int RAD_W      = 64;
    localparam int RES_W      = 32;
    localparam int DIV_CNT_W  = 7;
    localparam int SQRT_CNT_W = 5;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic REG_WINDOW_ROWS = 1'b0;
    localparam logic REG_HALF_WIDTH  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUB,
        ST_ROOT,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT
    } unit_state_t;

endpackage

@@ rtl/wsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module wsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/wsd_divsqrt.sv @@
// Bit-serial scaled divider followed by a bit-pair integer square root.
module wsd_divsqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wsd_pkg::NUM_W-1:0]   num,
    input  logic [wsd_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [wsd_pkg::RES_W-1:0]   root
);

    wsd_pkg::unit_state_t state_reg, state_next;

    logic [wsd_pkg::QUO_W-1:0]      dq_reg, dq_next;
    logic [wsd_pkg::DEN_W-1:0]      rem_reg, rem_next;
    logic [wsd_pkg::DEN_W-1:0]      den_reg, den_next;
    logic [wsd_pkg::DIV_CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [wsd_pkg::RAD_W-1:0]      x_reg, x_next;
    logic [wsd_pkg::RES_W+1:0]      srem_reg, srem_next;
    logic [wsd_pkg::RES_W-1:0]      root_reg, root_next;
    logic [wsd_pkg::SQRT_CNT_W-1:0] scnt_reg, scnt_next;
    logic                           done_reg, done_next;

    logic [wsd_pkg::DEN_W:0]        rem_sh;
    logic                           div_ge;
    logic [wsd_pkg::QUO_W-1:0]      dq_step;
    logic [wsd_pkg::RES_W+2:0]      srem_sh;
    logic [wsd_pkg::RES_W+2:0]      trial;
    logic                           sqrt_ge;

    // One quotient bit per cycle.
    assign rem_sh  = {rem_reg, dq_reg[wsd_pkg::QUO_W-1]};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign dq_step = {dq_reg[wsd_pkg::QUO_W-2:0], div_ge};

    // One root bit per cycle, two radicand bits consumed.
    assign srem_sh = {srem_reg[wsd_pkg::RES_W:0], x_reg[wsd_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sqrt_ge = srem_sh >= trial;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wsd_pkg::U_IDLE: begin
                if (start) begin
                    state_next = wsd_pkg::U_DIV;
                end
            end
            wsd_pkg::U_DIV: begin
                if (dcnt_reg == '0) begin
                    state_next = wsd_pkg::U_SQRT;
                end
            end
            wsd_pkg::U_SQRT: begin
                if (scnt_reg == '0) begin
                    state_next = wsd_pkg::U_IDLE;
                end
            end
            default: state_next = wsd_pkg::U_IDLE;
        endcase
    end

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dcnt_next = dcnt_reg;
        x_next    = x_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        scnt_next = scnt_reg;
        done_next = 1'b0;
        case (state_reg)
            wsd_pkg::U_IDLE: begin
                if (start) begin
                    dq_next   = {num, {wsd_pkg::FRAC_SHIFT{1'b0}}};
                    rem_next  = '0;
                    den_next  = den;
                    dcnt_next = wsd_pkg::DIV_CNT_W'(wsd_pkg::QUO_W - 1);
                end
            end
            wsd_pkg::U_DIV: begin
                rem_next  = div_ge ? wsd_pkg::DEN_W'(rem_sh - {1'b0, den_reg})
                                   : rem_sh[wsd_pkg::DEN_W-1:0];
                dq_next   = dq_step;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0) begin
                    // A quotient beyond 64 bits saturates.
                    x_next    = (|dq_step[wsd_pkg::QUO_W-1:wsd_pkg::RAD_W]) ? '1
                                : dq_step[wsd_pkg::RAD_W-1:0];
                    srem_next = '0;
                    root_next = '0;
                    scnt_next = wsd_pkg::SQRT_CNT_W'(wsd_pkg::RES_W - 1);
                end
            end
            wsd_pkg::U_SQRT: begin
                srem_next = sqrt_ge ? (wsd_pkg::RES_W+2)'(srem_sh - trial)
                                    : srem_sh[wsd_pkg::RES_W+1:0];
                root_next = {root_reg[wsd_pkg::RES_W-2:0], sqrt_ge};
                x_next    = {x_reg[wsd_pkg::RAD_W-3:0], 2'b00};
                scnt_next = scnt_reg - 1'b1;
                if (scnt_reg == '0) begin
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsd_pkg::U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        dcnt_reg <= dcnt_next;
        x_reg    <= x_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        scnt_reg <= scnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/window_std_dev_filter.sv @@
// Top level of the moving-window standard deviation filter.
//
// Samples arrive column by column, each column top to bottom, one word per
// cycle while s_tready is high. Every finished column is written to a
// 15-entry ring RAM as its sum, sum of squares and undefined flags. When a
// column completes a full window, the block reads the window's columns back
// one per cycle, forms (N*S2-S1^2)/(N*(N-1)) and passes it through a
// bit-serial divider and a bit-serial square root; the result is the
// standard deviation of the centre column in Q24.8. A sample that completes
// no window leaves the input open; one that does keeps the input closed
// while the window is read and the divider and square root unit runs (the
// unit is skipped when the window holds undefined data or N is below 2),
// and until the previous result has been taken.
// The finished result waits in an output register while the next samples
// are taken. Configuration writes are accepted in every cycle.
module window_std_dev_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_value
    input  logic [1:0]  s_tuser,   // [0] sample_undefined, [1] line_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] std_value, [43:32] centre_column, zero fill
    output logic [0:0]  m_tuser,   // [0] result_undefined
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int SW  = wsd_pkg::SAMPLE_W;
    localparam int CW  = wsd_pkg::SUM_W;
    localparam int QW  = wsd_pkg::SQ_W;
    localparam int AW  = wsd_pkg::RING_AW;

    wsd_pkg::ctl_state_t state_reg, state_next;

    logic [wsd_pkg::ROWS_W-1:0]    rows_reg;
    logic [wsd_pkg::HALF_W-1:0]    half_reg;
    logic [wsd_pkg::ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [wsd_pkg::SEEN_W-1:0]    seen_reg, seen_next;
    logic signed [CW-1:0]          cur_sum_reg, cur_sum_next;
    logic [QW-1:0]                 cur_sq_reg, cur_sq_next;
    logic                          cur_any_reg, cur_any_next;
    logic                          cur_ctr_reg, cur_ctr_next;
    logic [AW-1:0]                 wr_pos_reg, wr_pos_next;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;
    logic [wsd_pkg::WIDTH_W-1:0]   iss_reg, iss_next;
    logic                          pend_reg, pend_next;
    logic                          pend_ctr_reg, pend_ctr_next;
    logic signed [wsd_pkg::S1_W-1:0] s1_reg, s1_next;
    logic [wsd_pkg::S2_W-1:0]      s2_reg, s2_next;
    logic                          bad_reg, bad_next;
    logic [wsd_pkg::COL_W-1:0]     col_reg, col_next;
    logic [wsd_pkg::NUM_W-1:0]     a_reg, a_next;
    logic [63:0]                   b_reg, b_next;
    logic [wsd_pkg::DEN_W-1:0]     den_reg, den_next;
    logic [wsd_pkg::RES_W-1:0]     res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    logic [wsd_pkg::RES_W-1:0]     m_value_reg;
    logic                          m_undef_reg;
    logic [wsd_pkg::COL_W-1:0]     m_col_reg;

    logic                          accept;
    logic                          out_load;
    logic [wsd_pkg::ROWS_W-1:0]    rows_eff;
    logic [wsd_pkg::WIDTH_W-1:0]   width_w;
    logic [8:0]                    n_full;
    logic [wsd_pkg::N_W-1:0]       n_w;
    logic signed [SW-1:0]          sv;
    logic                          und;
    logic                          line_start;
    logic [SW-1:0]                 mag;
    logic [2*SW-1:0]               sq48;
    logic [QW:0]                   sq_sum;
    logic signed [CW-1:0]          base_sum;
    logic [QW-1:0]                 base_sq;
    logic                          base_any, base_ctr;
    logic [wsd_pkg::ROW_CNT_W-1:0] base_row;
    logic [wsd_pkg::SEEN_W-1:0]    base_seen, seen_inc;
    logic signed [CW-1:0]          sum_new;
    logic [QW-1:0]                 sq_new;
    logic                          any_new, ctr_new;
    logic                          last_row;
    logic                          ram_we, ram_re;
    logic [wsd_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
    logic [CW-1:0]                 rd_sum;
    logic [QW-1:0]                 rd_sq;
    logic                          rd_any, rd_ctr;
    logic [wsd_pkg::S1_W-1:0]      mag1;
    logic [wsd_pkg::NUM_W-1:0]     num_w;
    logic                          unit_start, unit_done;
    logic [wsd_pkg::RES_W-1:0]     unit_root;

    // An out-of-range window_rows register is clamped to 1..16.
    assign rows_eff = (rows_reg == '0) ? wsd_pkg::ROWS_W'(1)
                    : (rows_reg > wsd_pkg::ROWS_W'(wsd_pkg::MAX_ROWS))
                      ? wsd_pkg::ROWS_W'(wsd_pkg::MAX_ROWS) : rows_reg;
    assign width_w  = {half_reg, 1'b1};
    assign n_full   = {4'b0, rows_eff} * {5'b0, width_w};
    assign n_w      = n_full[wsd_pkg::N_W-1:0];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == wsd_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg == wsd_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    assign sv         = s_tdata;
    assign und        = s_tuser[0];
    assign line_start = s_tuser[1];

    assign base_sum  = line_start ? '0 : cur_sum_reg;
    assign base_sq   = line_start ? '0 : cur_sq_reg;
    assign base_any  = line_start ? 1'b0 : cur_any_reg;
    assign base_ctr  = line_start ? 1'b0 : cur_ctr_reg;
    assign base_row  = line_start ? '0 : row_cnt_reg;
    assign base_seen = line_start ? '0 : seen_reg;

    assign mag    = sv[SW-1] ? SW'(-sv) : sv;
    assign sq48   = mag * mag;
    assign sq_sum = {1'b0, base_sq} + {3'b000, sq48};

    assign sum_new = und ? base_sum : base_sum + {{(CW-SW){sv[SW-1]}}, sv};
    assign sq_new  = und ? base_sq : (sq_sum[QW] ? '1 : sq_sum[QW-1:0]);
    assign any_new = base_any | und;
    assign ctr_new = base_ctr | (und && (base_row == rows_eff[wsd_pkg::ROWS_W-1:1]));
    assign last_row = ({1'b0, base_row} + 5'd1) >= rows_eff;
    assign seen_inc = (base_seen == wsd_pkg::SEEN_W'(wsd_pkg::SEEN_LIMIT)) ? base_seen
                    : base_seen + 1'b1;

    assign ram_we    = accept && last_row;
    assign ram_wdata = {ctr_new, any_new, sq_new, sum_new};
    assign ram_re    = (state_reg == wsd_pkg::ST_READ) && (iss_reg < width_w);

    assign rd_sum = ram_rdata[CW-1:0];
    assign rd_sq  = ram_rdata[CW+QW-1:CW];
    assign rd_any = ram_rdata[CW+QW];
    assign rd_ctr = ram_rdata[CW+QW+1];

    assign mag1  = s1_reg[wsd_pkg::S1_W-1] ? wsd_pkg::S1_W'(-s1_reg) : s1_reg;
    assign num_w = ({2'b00, a_reg} > b_reg) ? wsd_pkg::NUM_W'({2'b00, a_reg} - b_reg) : '0;
    assign unit_start = (state_reg == wsd_pkg::ST_SUB) && !bad_reg;

    wsd_ram #(
        .WIDTH (wsd_pkg::ENTRY_W),
        .DEPTH (wsd_pkg::RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_pos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    wsd_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .num     (num_w),
        .den     (den_reg),
        .done    (unit_done),
        .root    (unit_root)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wsd_pkg::ST_IDLE: begin
                if (accept && last_row && (seen_inc >= {9'b0, width_w})) begin
                    state_next = wsd_pkg::ST_READ;
                end
            end
            wsd_pkg::ST_READ: begin
                if ((iss_reg == width_w) && !pend_reg) begin
                    state_next = wsd_pkg::ST_MUL;
                end
            end
            wsd_pkg::ST_MUL: state_next = wsd_pkg::ST_SUB;
            wsd_pkg::ST_SUB: state_next = bad_reg ? wsd_pkg::ST_OUT : wsd_pkg::ST_ROOT;
            wsd_pkg::ST_ROOT: begin
                if (unit_done) begin
                    state_next = wsd_pkg::ST_OUT;
                end
            end
            wsd_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = wsd_pkg::ST_IDLE;
                end
            end
            default: state_next = wsd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        row_cnt_next  = row_cnt_reg;
        seen_next     = seen_reg;
        cur_sum_next  = cur_sum_reg;
        cur_sq_next   = cur_sq_reg;
        cur_any_next  = cur_any_reg;
        cur_ctr_next  = cur_ctr_reg;
        wr_pos_next   = wr_pos_reg;
        rd_addr_next  = rd_addr_reg;
        iss_next      = iss_reg;
        pend_next     = 1'b0;
        pend_ctr_next = 1'b0;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        bad_next      = bad_reg;
        col_next      = col_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        den_next      = den_reg;
        res_next      = res_reg;
        case (state_reg)
            wsd_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!last_row) begin
                        row_cnt_next = base_row + 1'b1;
                        seen_next    = base_seen;
                        cur_sum_next = sum_new;
                        cur_sq_next  = sq_new;
                        cur_any_next = any_new;
                        cur_ctr_next = ctr_new;
                    end else begin
                        row_cnt_next = '0;
                        seen_next    = seen_inc;
                        cur_sum_next = '0;
                        cur_sq_next  = '0;
                        cur_any_next = 1'b0;
                        cur_ctr_next = 1'b0;
                        wr_pos_next  = (wr_pos_reg == AW'(wsd_pkg::RING_DEPTH - 1)) ? '0
                                     : wr_pos_reg + 1'b1;
                        // The window is read back newest column first.
                        rd_addr_next = wr_pos_reg;
                        iss_next     = '0;
                        s1_next      = '0;
                        s2_next      = '0;
                        bad_next     = 1'b0;
                        col_next     = wsd_pkg::COL_W'(seen_inc - 1'b1 - {10'b0, half_reg});
                    end
                end
            end
            wsd_pkg::ST_READ: begin
                if (ram_re) begin
                    rd_addr_next  = (rd_addr_reg == '0) ? AW'(wsd_pkg::RING_DEPTH - 1)
                                  : rd_addr_reg - 1'b1;
                    iss_next      = iss_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_ctr_next = (iss_reg == {1'b0, half_reg});
                end
                if (pend_reg) begin
                    s1_next  = s1_reg + {{(wsd_pkg::S1_W-CW){rd_sum[CW-1]}}, rd_sum};
                    s2_next  = s2_reg + {4'b0, rd_sq};
                    bad_next = bad_reg | rd_any | (pend_ctr_reg & rd_ctr);
                end
            end
            wsd_pkg::ST_MUL: begin
                a_next   = wsd_pkg::NUM_W'(s2_reg) * wsd_pkg::NUM_W'(n_w);
                b_next   = {32'b0, mag1} * {32'b0, mag1};
                den_next = wsd_pkg::DEN_W'({8'b0, n_w} * {8'b0, n_w - 1'b1});
                if (n_w < 8'd2) begin
                    bad_next = 1'b1;
                end
            end
            wsd_pkg::ST_SUB: begin
                res_next = '0;
            end
            wsd_pkg::ST_ROOT: begin
                if (unit_done) begin
                    res_next = unit_root;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wsd_pkg::ST_IDLE;
            rows_reg    <= wsd_pkg::ROWS_W'(3);
            half_reg    <= wsd_pkg::HALF_W'(1);
            row_cnt_reg <= '0;
            seen_reg    <= '0;
            cur_sum_reg <= '0;
            cur_sq_reg  <= '0;
            cur_any_reg <= 1'b0;
            cur_ctr_reg <= 1'b0;
            wr_pos_reg  <= '0;
            iss_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            seen_reg    <= seen_next;
            cur_sum_reg <= cur_sum_next;
            cur_sq_reg  <= cur_sq_next;
            cur_any_reg <= cur_any_next;
            cur_ctr_reg <= cur_ctr_next;
            wr_pos_reg  <= wr_pos_next;
            iss_reg     <= iss_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wsd_pkg::REG_WINDOW_ROWS: rows_reg <= cfg_data;
                    wsd_pkg::REG_HALF_WIDTH:  half_reg <= cfg_data[wsd_pkg::HALF_W-1:0];
                    default: ;
                endcase
            end
        end
        rd_addr_reg  <= rd_addr_next;
        pend_ctr_reg <= pend_ctr_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        bad_reg      <= bad_next;
        col_reg      <= col_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        den_reg      <= den_next;
        res_reg      <= res_next;
        if (out_load) begin
            m_value_reg <= res_next;
            m_undef_reg <= bad_reg;
            m_col_reg   <= col_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_col_reg, m_value_reg};
    assign m_tuser  = m_undef_reg;

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_undef_reg) |-> (m_value_reg == '0))
        else $error("undefined result carries a non-zero value");

    a_done_in_root: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_done |-> (state_reg == wsd_pkg::ST_ROOT))
        else $error("root unit finished outside the root wait");

    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsd_pkg::ST_READ) |-> (iss_reg <= width_w))
        else $error("window read ran past the window width");

    a_ring_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(ram_we) |-> ($past(wr_pos_reg) != wr_pos_reg))
        else $error("ring write position did not advance after a column write");

endmodule
